/* hw/rtl/tqc_pkg.sv */
// Shared types and constants of the ticketed queue with cancel.
// Holds field widths, operation and status codes, the controller states
// and the entry and result records. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tqc_pkg;

  // default queue depth, overridable on the top level
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // field widths of the channels
  localparam int unsigned OP_W     = 2;
  localparam int unsigned TICKET_W = 16;
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GROUPS_W = 5;
  localparam int unsigned PEOPLE_W = 12;

  // saturation limits of the reported totals
  localparam int unsigned GROUPS_MAX = (1 << GROUPS_W) - 1;
  localparam int unsigned PEOPLE_MAX = (1 << PEOPLE_W) - 1;

  // highest ticket before the wrap back to the first ticket
  localparam logic [TICKET_W-1:0] TICKET_LAST  = '1;
  localparam logic [TICKET_W-1:0] TICKET_FIRST = TICKET_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_DEQ    = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TICKET_W-1:0] ticket_out;
    logic [SIZE_W-1:0]   size_out;
    logic [GROUPS_W-1:0] groups_waiting;
    logic [PEOPLE_W-1:0] people_waiting;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/tqc_req_if.sv */
// Request channel of the ticketed queue: valid/ready plus operation fields.
// Depends on tqc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tqc_req_if;
  import tqc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SIZE_W-1:0]   group_size;
  logic [TICKET_W-1:0] ticket;

  modport source (output valid, output operation, output group_size, output ticket,
                  input ready);
  modport sink   (input valid, input operation, input group_size, input ticket,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqc_res_if.sv */
// Result channel of the ticketed queue: valid/ready plus result fields.
// Depends on tqc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tqc_res_if;
  import tqc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TICKET_W-1:0] ticket_out;
  logic [SIZE_W-1:0]   size_out;
  logic [GROUPS_W-1:0] groups_waiting;
  logic [PEOPLE_W-1:0] people_waiting;

  modport source (output valid, output status, output ticket_out, output size_out,
                  output groups_waiting, output people_waiting, input ready);
  modport sink   (input valid, input status, input ticket_out, input size_out,
                  input groups_waiting, input people_waiting, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tqc_res_buf.sv */
// Output register of the ticketed queue: holds one finished result item
// until the sink takes it. Depends on tqc_pkg and tqc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module tqc_res_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire tqc_pkg::res_t in_data_i,
  output logic               in_ready_o,
  tqc_res_if.source          res_o
);
  import tqc_pkg::*;

  logic valid_q;
  res_t data_q;

  // take a new item when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || res_o.ready;

  // track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // load payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  // drive the channel
  assign res_o.valid          = valid_q;
  assign res_o.status         = data_q.status;
  assign res_o.ticket_out     = data_q.ticket_out;
  assign res_o.size_out       = data_q.size_out;
  assign res_o.groups_waiting = data_q.groups_waiting;
  assign res_o.people_waiting = data_q.people_waiting;

endmodule

`default_nettype wire

/* hw/rtl/ticketed_queue_with_cancel.sv */
// Top level of the ticketed queue with cancel: controller, entry memory
// and totals. Depends on tqc_pkg, tqc_req_if, tqc_res_if and tqc_res_buf.
//
// Ordered queue of groups kept head first in one entry memory (ticket and
// size per entry, one read and one write port, registered read data).
// Enqueue, the no-op code and a cancel or dequeue on an empty queue go
// from acceptance straight to the result. A cancel or a dequeue on a
// non-empty queue first runs the ticket search, which reads one entry per
// cycle from the head, and then, where the found entry has others behind
// it, closes the gap, moving one entry per cycle through the same memory
// ports. The result item waits in an output register, so a new item is
// taken while the last one is still unclaimed. No clearing pass is needed
// after reset: only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module ticketed_queue_with_cancel #(
  parameter int unsigned QUEUE_DEPTH = tqc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tqc_req_if.sink   req_i,
  tqc_res_if.source res_o
);
  import tqc_pkg::*;

  localparam int unsigned IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW  = $clog2(QUEUE_DEPTH * ((1 << SIZE_W) - 1) + 1);
  localparam int unsigned CWX = (CW > GROUPS_W) ? CW : GROUPS_W;
  localparam int unsigned SWX = (SW > PEOPLE_W) ? SW : PEOPLE_W;

  // controller and totals
  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [TICKET_W-1:0] tail_q, tail_d;
  logic [TICKET_W-1:0] prev_q, prev_d;
  logic [TICKET_W-1:0] want_q, want_d;
  logic                deq_q, deq_d;
  logic [IW-1:0]       idx_q, idx_d;
  status_e             rstat_q, rstat_d;
  logic [TICKET_W-1:0] rtick_q, rtick_d;
  logic [SIZE_W-1:0]   rsize_q, rsize_d;

  // entry memory
  entry_t              mem_q [QUEUE_DEPTH];
  entry_t              rdata_q;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  // result path
  logic                res_valid, res_ready;
  res_t                res_data;

  // shared decisions
  op_e                 op;
  logic                req_fire;
  logic [CW-1:0]       idx_ext;
  logic                last_old, match, shift_done;
  logic                is_empty, is_full;
  logic [TICKET_W-1:0] next_ticket;

  assign op          = op_e'(req_i.operation);
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign idx_ext     = CW'(idx_q);
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == CW'(QUEUE_DEPTH));
  // search reads the entry at idx_q; count still holds the old fill
  assign last_old    = (idx_ext == count_q - CW'(1));
  assign match       = deq_q || (rdata_q.ticket == want_q);
  // during the move count already holds the new fill
  assign shift_done  = (idx_ext + CW'(1) == count_q);
  assign next_ticket = (is_empty || tail_q == TICKET_LAST) ? TICKET_FIRST
                                                           : tail_q + TICKET_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (op) inside
            OP_ENQ, OP_NOP:    state_d = S_RESP;
            OP_CANCEL, OP_DEQ: state_d = is_empty ? S_RESP : S_SEARCH;
          endcase
        end
      end
      S_SEARCH: begin
        if (last_old) begin
          state_d = S_RESP;
        end else if (match) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    sum_d     = sum_q;
    tail_d    = tail_q;
    prev_d    = prev_q;
    want_d    = want_q;
    deq_d     = deq_q;
    idx_d     = idx_q;
    rstat_d   = rstat_q;
    rtick_d   = rtick_q;
    rsize_d   = rsize_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_valid = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          want_d  = req_i.ticket;
          deq_d   = (op == OP_DEQ);
          idx_d   = '0;
          rstat_d = ST_OK;
          rtick_d = '0;
          rsize_d = '0;
          unique case (op) inside
            OP_ENQ: begin
              if (is_full) begin
                rstat_d = ST_FULL;
              end else begin
                // append at the tail
                mem_we    = 1'b1;
                mem_waddr = IW'(count_q);
                mem_wdata = '{ticket: next_ticket, size: req_i.group_size};
                count_d   = count_q + CW'(1);
                sum_d     = sum_q + SW'(req_i.group_size);
                tail_d    = next_ticket;
                rtick_d   = next_ticket;
                rsize_d   = req_i.group_size;
              end
            end
            OP_CANCEL, OP_DEQ: begin
              if (is_empty) begin
                rstat_d = (op == OP_DEQ) ? ST_EMPTY : ST_NOT_FOUND;
              end else begin
                // fetch the head
                mem_re = 1'b1;
              end
            end
            OP_NOP: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          // drop the entry and report it
          rtick_d = rdata_q.ticket;
          rsize_d = rdata_q.size;
          count_d = count_q - CW'(1);
          sum_d   = sum_q - SW'(rdata_q.size);
          if (last_old) begin
            tail_d = prev_q;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IW'(idx_ext + CW'(1));
          end
        end else if (last_old) begin
          rstat_d = ST_NOT_FOUND;
        end else begin
          // advance to the next entry
          prev_d    = rdata_q.ticket;
          mem_re    = 1'b1;
          mem_raddr = IW'(idx_ext + CW'(1));
          idx_d     = IW'(idx_ext + CW'(1));
        end
      end
      S_SHIFT: begin
        // move the entry behind the gap one place forward
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rdata_q;
        if (!shift_done) begin
          mem_re    = 1'b1;
          mem_raddr = IW'(idx_ext + CW'(2));
          idx_d     = IW'(idx_ext + CW'(1));
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    tail_q  <= tail_d;
    prev_q  <= prev_d;
    want_q  <= want_d;
    deq_q   <= deq_d;
    idx_q   <= idx_d;
    rstat_q <= rstat_d;
    rtick_q <= rtick_d;
    rsize_q <= rsize_d;
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // saturate the reported totals
  logic [CWX-1:0] count_ext;
  logic [SWX-1:0] sum_ext;

  assign count_ext = CWX'(count_q);
  assign sum_ext   = SWX'(sum_q);

  always_comb begin
    res_data.status     = rstat_q;
    res_data.ticket_out = rtick_q;
    res_data.size_out   = rsize_q;
    res_data.groups_waiting = (count_ext > CWX'(GROUPS_MAX)) ? GROUPS_W'(GROUPS_MAX)
                                                             : count_ext[GROUPS_W-1:0];
    res_data.people_waiting = (sum_ext > SWX'(PEOPLE_MAX)) ? PEOPLE_W'(PEOPLE_MAX)
                                                           : sum_ext[PEOPLE_W-1:0];
  end

  tqc_res_buf u_res_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (res_valid),
    .in_data_i  (res_data),
    .in_ready_o (res_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench of the ticketed queue with cancel.
// Drives requests, predicts every result from its own queue model and checks results in order.
// Depends on tqc_pkg, tqc_req_if, tqc_res_if and the ticketed_queue_with_cancel top level.
`timescale 1ns / 1ps

module testbench;
  import tqc_pkg::*;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RESULT_HOLD   = 300;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  logic clk_i = 1'b0;
  logic rst_ni;

  tqc_req_if req_ch ();
  tqc_res_if res_ch ();

  ticketed_queue_with_cancel #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch)
  );

  // predicted queue contents, head first, and results still owed by the block
  entry_t      waiting_q[$];
  res_t        owed_results[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  // long holds asked for by the tests, and those the receiver has started
  int unsigned hold_request   = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  always #CLK_HALF clk_i = ~clk_i;

  // Apply one operation to the predicted queue and return the result it gives.
  function automatic res_t apply_operation(op_e op, logic [SIZE_W-1:0] sz,
                                           logic [TICKET_W-1:0] tk);
    res_t        r;
    entry_t      e;
    int          pos;
    int unsigned sum;
    r        = '0;
    r.status = ST_OK;
    pos      = -1;
    sum      = 0;
    case (op)
      OP_ENQ: begin
        if (waiting_q.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (waiting_q.size() == 0) begin
            e.ticket = TICKET_FIRST;
          end else if (waiting_q[$].ticket == TICKET_LAST) begin
            e.ticket = TICKET_FIRST;
          end else begin
            e.ticket = waiting_q[$].ticket + 1'b1;
          end
          e.size = sz;
          waiting_q.push_back(e);
          r.ticket_out = e.ticket;
          r.size_out   = e.size;
        end
      end
      OP_CANCEL: begin
        // take the match nearest the head
        foreach (waiting_q[i]) begin
          if (pos < 0 && waiting_q[i].ticket == tk) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.ticket_out = waiting_q[pos].ticket;
          r.size_out   = waiting_q[pos].size;
          waiting_q.delete(pos);
        end
      end
      OP_DEQ: begin
        if (waiting_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          e            = waiting_q.pop_front();
          r.ticket_out = e.ticket;
          r.size_out   = e.size;
        end
      end
      default: ;
    endcase
    foreach (waiting_q[i]) sum += waiting_q[i].size;
    r.groups_waiting = (waiting_q.size() > GROUPS_MAX) ? GROUPS_W'(GROUPS_MAX)
                                                       : GROUPS_W'(waiting_q.size());
    r.people_waiting = (sum > PEOPLE_MAX) ? PEOPLE_W'(PEOPLE_MAX) : PEOPLE_W'(sum);
    return r;
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
    end
  endtask

  // Offer one item, wait for it to be taken, then record the result it owes.
  task automatic send_item(op_e op, logic [SIZE_W-1:0] sz, logic [TICKET_W-1:0] tk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.group_size <= sz;
    req_ch.ticket     <= tk;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    owed_results.push_back(apply_operation(op, sz, tk));
  endtask

  // Stall or release the result channel, with long holds on request.
  always @(posedge clk_i) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = RESULT_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each taken result with the oldest owed one.
  always @(posedge clk_i) begin : check_results
    res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (owed_results.size() == 0) begin
        note_mismatch("result item with none outstanding");
      end else begin
        want = owed_results.pop_front();
        check_field("status", 32'(res_ch.status), 32'(want.status));
        check_field("ticket_out", 32'(res_ch.ticket_out), 32'(want.ticket_out));
        check_field("size_out", 32'(res_ch.size_out), 32'(want.size_out));
        check_field("groups_waiting", 32'(res_ch.groups_waiting),
                    32'(want.groups_waiting));
        check_field("people_waiting", 32'(res_ch.people_waiting),
                    32'(want.people_waiting));
      end
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item moved in %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Requests on an empty queue: dequeue, cancel of the lowest and highest ticket, no-op.
  task automatic test_empty_queue();
    send_item(OP_DEQ, 8'hFF, 16'hFFFF);
    send_item(OP_CANCEL, 8'h00, 16'h0000);
    send_item(OP_CANCEL, 8'hFF, 16'hFFFF);
    send_item(OP_NOP, 8'hFF, 16'hFFFF);
  endtask

  // Fill to the limit with extreme sizes, then hit the full and not-found cases.
  task automatic test_fill_to_full();
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < DEPTH; i++) begin
      sz = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom_range(255));
      send_item(OP_ENQ, sz, 16'($urandom_range(65535)));
    end
    send_item(OP_ENQ, 8'd255, 16'hFFFF);
    send_item(OP_CANCEL, 8'd0, 16'd0);
    send_item(OP_CANCEL, 8'($urandom_range(255)), 16'(DEPTH + 1));
    send_item(OP_NOP, 8'd0, 16'd0);
  endtask

  // Cancel from the middle, the head and the tail, then dequeue.
  task automatic test_cancel_positions();
    send_item(OP_CANCEL, 8'd0, 16'(DEPTH / 2));
    send_item(OP_CANCEL, 8'd0, 16'd1);
    send_item(OP_CANCEL, 8'd0, 16'(DEPTH));
    send_item(OP_DEQ, 8'd0, 16'd0);
  endtask

  // Mostly well-formed traffic in bursts that lean toward filling or draining.
  task automatic test_random_mix(int unsigned n_items);
    int unsigned       pick;
    bit                fill_lean;
    op_e               op;
    logic [SIZE_W-1:0] sz;
    logic [TICKET_W-1:0] tk;
    fill_lean = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 48 == 0) fill_lean = 1'($urandom_range(1));
      pick = $urandom_range(99);
      sz   = SIZE_W'($urandom_range(255));
      tk   = TICKET_W'($urandom_range(65535));
      if (pick < (fill_lean ? 55 : 25)) begin
        op = OP_ENQ;
      end else if (pick < 80) begin
        op = OP_CANCEL;
        if (waiting_q.size() != 0) tk = waiting_q[$urandom_range(waiting_q.size() - 1)].ticket;
      end else if (pick < 90 + (fill_lean ? 0 : 5)) begin
        op = OP_DEQ;
      end else begin
        // noise: stray cancels, near misses past the tail and no-ops
        case ($urandom_range(2))
          0: op = OP_CANCEL;
          1: begin
            op = OP_CANCEL;
            tk = (waiting_q.size() != 0) ? waiting_q[$].ticket + 1'b1 : 16'd0;
          end
          default: op = OP_NOP;
        endcase
      end
      send_item(op, sz, tk);
    end
  endtask

  // Hold the result channel for a long stretch while requests keep coming.
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request++;
    for (int i = 0; i < 40; i++) begin
      send_item(($urandom_range(1) != 0) ? OP_ENQ : OP_DEQ, 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_NOP;
    req_ch.group_size <= '0;
    req_ch.ticket     <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 56;
    test_empty_queue();
    test_fill_to_full();
    test_cancel_positions();
    test_random_mix(500);
    send_idle_pct = 56;
    recv_idle_pct = 9;
    test_random_mix(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(400);
    test_receiver_hold();

    // let the last results come out, then allow for a straggler
    req_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
